[rtl/icra_pkg.sv]
// Shared types, constants and helper functions of the mirror-border convolution block.
// No dependencies; every other file of the block but icra_ram imports this package.
package icra_pkg;

	localparam int PIXEL_BITS     = 16;
	localparam int COEF_BITS      = 16;
	localparam int COEF_FRAC_BITS = 12;
	localparam int KERNEL_MAX     = 3;
	localparam int KSIZE_BITS     = 2;
	localparam int DIM_BITS       = 9;
	localparam int DIM_MIN        = 4;
	localparam int DIM_MAX        = 256;
	localparam int COORD_BITS     = 8;
	localparam int POS_BITS       = 16;
	localparam int SIZE_BITS      = POS_BITS + 1;
	localparam int STORE_DEPTH    = DIM_MAX * DIM_MAX;
	localparam int ROW_BITS       = KERNEL_MAX * COEF_BITS;
	localparam int PROD_BITS      = PIXEL_BITS + 1 + COEF_BITS;
	localparam int ACC_BITS       = PROD_BITS + 3;
	localparam int IDX_BITS       = DIM_BITS + 2;
	localparam int DIV_CNT_BITS   = $clog2(POS_BITS);
	localparam int CFG_IDX_BITS   = 3;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_WIDTH   = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_HEIGHT  = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_KERNEL_WIDTH  = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_KERNEL_HEIGHT = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] CFG_ROW_TOP       = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] CFG_ROW_MID       = 3'd5;
	localparam logic [CFG_IDX_BITS-1:0] CFG_ROW_BOTTOM    = 3'd6;

	// Input beat function codes.
	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_READ = 1'b1;

	typedef logic signed [IDX_BITS-1:0] idx_t;

	typedef struct packed {
		logic                  func;
		logic [PIXEL_BITS-1:0] pixel;
	} in_beat_t;

	typedef struct packed {
		logic [PIXEL_BITS-1:0] value;
		logic                  clipped;
		logic                  last;
	} out_beat_t;

	typedef struct packed {
		logic                  start;
		logic [POS_BITS-1:0]   dividend;
		logic [DIM_BITS-1:0]   divisor;
	} div_req_t;

	typedef struct packed {
		logic                  done;
		logic [COORD_BITS-1:0] quotient;
		logic [COORD_BITS-1:0] remainder;
	} div_res_t;

	typedef struct packed {
		logic                        clear;
		logic                        tap_vld;
		logic signed [COEF_BITS-1:0] coef;
	} mac_ctl_t;

	typedef struct packed {
		logic                  busy;
		logic [PIXEL_BITS-1:0] value;
		logic                  clipped;
	} mac_st_t;

	function automatic logic [DIM_BITS-1:0] clamp_dim(input logic [DIM_BITS-1:0] v);
		logic [DIM_BITS-1:0] r;
		r = v;
		if (v < DIM_BITS'(DIM_MIN)) r = DIM_BITS'(DIM_MIN);
		if (v > DIM_BITS'(DIM_MAX)) r = DIM_BITS'(DIM_MAX);
		return r;
	endfunction

	function automatic logic [KSIZE_BITS-1:0] clamp_ksize(input logic [KSIZE_BITS-1:0] v);
		logic [KSIZE_BITS-1:0] r;
		r = v;
		if (v < KSIZE_BITS'(1)) r = KSIZE_BITS'(1);
		if (v > KSIZE_BITS'(KERNEL_MAX)) r = KSIZE_BITS'(KERNEL_MAX);
		return r;
	endfunction

	// Reflect an index one step outside the frame back inside: -k goes to k,
	// and size+k goes to size-1-k.
	function automatic logic [COORD_BITS-1:0] mirror_idx(input idx_t idx,
		input logic [DIM_BITS-1:0] size);
		idx_t s;
		idx_t m;
		s = idx_t'(size);
		m = idx;
		if (m < idx_t'(0)) m = -m;
		if (m >= s) m = (s - idx_t'(1)) + (s - m);
		return m[COORD_BITS-1:0];
	endfunction

	function automatic logic signed [COEF_BITS-1:0] coef_of(input logic [ROW_BITS-1:0] row,
		input logic [KSIZE_BITS-1:0] col);
		logic signed [COEF_BITS-1:0] c;
		case (col)
			2'd0:    c = row[0*COEF_BITS +: COEF_BITS];
			2'd1:    c = row[1*COEF_BITS +: COEF_BITS];
			2'd2:    c = row[2*COEF_BITS +: COEF_BITS];
			default: c = row[0*COEF_BITS +: COEF_BITS];
		endcase
		return c;
	endfunction

endpackage

[rtl/image_convolution_reflect_abs_top.sv]
// Top level of the mirror-border convolution block for kernels up to 3x3:
// configuration, sequencer and frame memory. Depends on icra_pkg, icra_ram, icra_div and icra_mac.
//
// A frame is loaded one pixel beat at a time in raster order (func 0), one beat
// per cycle while the input is not stalled, with no result. Once the frame is
// full, each request beat (func 1) returns one filtered pixel in raster order,
// and the beat flagged last ends the frame. A request then holds the input
// stalled while it passes through the tap, drain and output states; the single
// port of the frame memory yields one kernel tap per cycle into the shared
// multiply-accumulate unit. The first request after any configuration write,
// unless a frame has completed loading since, first splits the read position
// into row and column with a bit-serial divider. A result waits in the output
// register while further load beats are taken. Requests during loading are
// accepted and give no result; a load while results are pending restarts the
// frame at position zero.
module image_convolution_reflect_abs_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [icra_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [icra_pkg::ROW_BITS-1:0]    cfg_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  icra_pkg::in_beat_t               in_data,
	output logic                             out_valid,
	input  logic                             out_stall,
	output icra_pkg::out_beat_t              out_data
);
	import icra_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_DIV   = 3'd1;
	localparam logic [2:0] ST_TAP   = 3'd2;
	localparam logic [2:0] ST_DRAIN = 3'd3;
	localparam logic [2:0] ST_FIN   = 3'd4;

	logic [DIM_BITS-1:0]   img_w_q;
	logic [DIM_BITS-1:0]   img_h_q;
	logic [KSIZE_BITS-1:0] ker_w_q;
	logic [KSIZE_BITS-1:0] ker_h_q;
	logic [ROW_BITS-1:0]   row_top_q;
	logic [ROW_BITS-1:0]   row_mid_q;
	logic [ROW_BITS-1:0]   row_bot_q;

	logic [2:0]            state_q;
	logic                  frame_ready_q;
	logic                  coord_ok_q;
	logic [POS_BITS-1:0]   load_pos_q;
	logic [POS_BITS-1:0]   read_pos_q;
	logic [COORD_BITS-1:0] rd_x_q;
	logic [COORD_BITS-1:0] rd_y_q;
	logic [KSIZE_BITS-1:0] r_q;
	logic [KSIZE_BITS-1:0] c_q;
	logic                  out_valid_q;
	out_beat_t             out_data_q;

	logic [DIM_BITS-1:0]   w_c;
	logic [DIM_BITS-1:0]   h_c;
	logic [KSIZE_BITS-1:0] kw_c;
	logic [KSIZE_BITS-1:0] kh_c;
	logic [KSIZE_BITS-1:0] cx;
	logic [KSIZE_BITS-1:0] cy;
	logic [SIZE_BITS-1:0]  size;
	logic [POS_BITS-1:0]   size_m1;

	logic                  in_acc;
	logic                  is_load;
	logic                  is_read;
	logic [POS_BITS-1:0]   ld_pos;
	logic [POS_BITS-1:0]   ld_addr;
	logic [SIZE_BITS-1:0]  ld_next;
	logic [POS_BITS-1:0]   rd_pos_eff;
	logic [SIZE_BITS-1:0]  rd_next;
	logic                  rd_last;
	logic [DIM_BITS-1:0]   x_next;
	logic                  out_free;
	logic                  last_tap;

	logic [COORD_BITS-1:0]          xx;
	logic [COORD_BITS-1:0]          yy;
	logic [COORD_BITS+DIM_BITS-1:0] tap_lin;
	logic [POS_BITS-1:0]            tap_addr;
	logic [ROW_BITS-1:0]            row_sel;

	logic                  ram_we;
	logic [POS_BITS-1:0]   ram_addr;
	logic [PIXEL_BITS-1:0] ram_rdata;

	div_req_t div_req;
	div_res_t div_res;
	mac_ctl_t mac_ctl;
	mac_st_t  mac_st;

	// Clamped configuration and frame size.
	assign w_c     = clamp_dim(img_w_q);
	assign h_c     = clamp_dim(img_h_q);
	assign kw_c    = clamp_ksize(ker_w_q);
	assign kh_c    = clamp_ksize(ker_h_q);
	assign cx      = kw_c >> 1;
	assign cy      = kh_c >> 1;
	assign size    = SIZE_BITS'(w_c) * SIZE_BITS'(h_c);
	assign size_m1 = POS_BITS'(size - SIZE_BITS'(1));

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid & ~in_stall;
	assign is_load  = in_acc & (in_data.func == FUNC_LOAD);
	assign is_read  = in_acc & (in_data.func == FUNC_READ) & frame_ready_q;

	// A load in the ready phase restarts the frame; positions past a shrunk
	// frame collapse onto its final pixel.
	assign ld_pos     = frame_ready_q ? '0 : load_pos_q;
	assign ld_addr    = ({1'b0, ld_pos} >= size) ? size_m1 : ld_pos;
	assign ld_next    = {1'b0, ld_addr} + SIZE_BITS'(1);
	assign rd_pos_eff = ({1'b0, read_pos_q} >= size) ? size_m1 : read_pos_q;
	assign rd_next    = {1'b0, read_pos_q} + SIZE_BITS'(1);
	assign rd_last    = rd_next >= size;
	assign x_next     = {1'b0, rd_x_q} + DIM_BITS'(1);
	assign out_free   = ~out_valid_q | ~out_stall;
	assign last_tap   = (r_q == kh_c - KSIZE_BITS'(1)) && (c_q == kw_c - KSIZE_BITS'(1));

	// Tap address: mirrored row and column around the current output pixel.
	assign xx = mirror_idx(idx_t'(rd_x_q) + idx_t'(c_q) - idx_t'(cx), w_c);
	assign yy = mirror_idx(idx_t'(rd_y_q) + idx_t'(r_q) - idx_t'(cy), h_c);
	assign tap_lin  = (COORD_BITS+DIM_BITS)'(yy) * (COORD_BITS+DIM_BITS)'(w_c)
		+ (COORD_BITS+DIM_BITS)'(xx);
	assign tap_addr = tap_lin[POS_BITS-1:0];

	always_comb begin
		case (r_q)
			2'd0:    row_sel = row_top_q;
			2'd1:    row_sel = row_mid_q;
			2'd2:    row_sel = row_bot_q;
			default: row_sel = row_top_q;
		endcase
	end

	assign ram_we   = is_load;
	assign ram_addr = (state_q == ST_IDLE) ? ld_addr : tap_addr;

	assign div_req.start    = is_read & ~coord_ok_q;
	assign div_req.dividend = rd_pos_eff;
	assign div_req.divisor  = w_c;

	assign mac_ctl.clear   = is_read;
	assign mac_ctl.tap_vld = (state_q == ST_TAP);
	assign mac_ctl.coef    = coef_of(row_sel, c_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			img_w_q       <= DIM_BITS'(DIM_MAX);
			img_h_q       <= DIM_BITS'(DIM_MAX);
			ker_w_q       <= KSIZE_BITS'(KERNEL_MAX);
			ker_h_q       <= KSIZE_BITS'(KERNEL_MAX);
			row_top_q     <= '0;
			row_mid_q     <= '0;
			row_bot_q     <= '0;
			state_q       <= ST_IDLE;
			frame_ready_q <= 1'b0;
			coord_ok_q    <= 1'b0;
			load_pos_q    <= '0;
			read_pos_q    <= '0;
			rd_x_q        <= '0;
			rd_y_q        <= '0;
			r_q           <= '0;
			c_q           <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (is_load) begin
						if (ld_next >= size) begin
							frame_ready_q <= 1'b1;
							load_pos_q    <= '0;
							read_pos_q    <= '0;
							rd_x_q        <= '0;
							rd_y_q        <= '0;
							coord_ok_q    <= 1'b1;
						end else begin
							frame_ready_q <= 1'b0;
							load_pos_q    <= ld_next[POS_BITS-1:0];
						end
					end else if (is_read) begin
						read_pos_q <= rd_pos_eff;
						r_q        <= '0;
						c_q        <= '0;
						state_q    <= coord_ok_q ? ST_TAP : ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_res.done) begin
						rd_x_q     <= div_res.remainder;
						rd_y_q     <= div_res.quotient;
						coord_ok_q <= 1'b1;
						state_q    <= ST_TAP;
					end
				end
				ST_TAP: begin
					if (last_tap) begin
						state_q <= ST_DRAIN;
					end else if (c_q == kw_c - KSIZE_BITS'(1)) begin
						c_q <= '0;
						r_q <= r_q + KSIZE_BITS'(1);
					end else begin
						c_q <= c_q + KSIZE_BITS'(1);
					end
				end
				ST_DRAIN: begin
					if (!mac_st.busy) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
						if (rd_last) begin
							frame_ready_q <= 1'b0;
							load_pos_q    <= '0;
							read_pos_q    <= '0;
							rd_x_q        <= '0;
							rd_y_q        <= '0;
						end else begin
							read_pos_q <= rd_next[POS_BITS-1:0];
							if (x_next == w_c) begin
								rd_x_q <= '0;
								rd_y_q <= rd_y_q + COORD_BITS'(1);
							end else begin
								rd_x_q <= x_next[COORD_BITS-1:0];
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			// Any register write may change the width, so the cached row and
			// column of the read position are recomputed on the next request.
			if (cfg_we) begin
				coord_ok_q <= 1'b0;
				case (cfg_index)
					CFG_IMAGE_WIDTH:   img_w_q   <= cfg_data[DIM_BITS-1:0];
					CFG_IMAGE_HEIGHT:  img_h_q   <= cfg_data[DIM_BITS-1:0];
					CFG_KERNEL_WIDTH:  ker_w_q   <= cfg_data[KSIZE_BITS-1:0];
					CFG_KERNEL_HEIGHT: ker_h_q   <= cfg_data[KSIZE_BITS-1:0];
					CFG_ROW_TOP:       row_top_q <= cfg_data;
					CFG_ROW_MID:       row_mid_q <= cfg_data;
					CFG_ROW_BOTTOM:    row_bot_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FIN && out_free) begin
			out_data_q.value   <= mac_st.value;
			out_data_q.clipped <= mac_st.clipped;
			out_data_q.last    <= rd_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	icra_ram #(
		.WIDTH (PIXEL_BITS),
		.DEPTH (STORE_DEPTH)
	) u_frame_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (in_data.pixel),
		.rdata (ram_rdata)
	);

	icra_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.res    (div_res)
	);

	icra_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.pixel  (ram_rdata),
		.st     (mac_st)
	);

endmodule

[rtl/icra_ram.sv]
// Generic single-port RAM with registered read data.
// No dependencies.
module icra_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

[rtl/icra_div.sv]
// Iterative restoring divider: splits a raster position into row and column,
// one quotient bit per cycle. Depends on icra_pkg.
module icra_div (
	input  logic               clk,
	input  logic               arst_n,
	input  icra_pkg::div_req_t req,
	output icra_pkg::div_res_t res
);
	import icra_pkg::*;

	logic                    busy_q;
	logic                    done_q;
	logic [DIV_CNT_BITS-1:0] cnt_q;
	logic [POS_BITS-1:0]     quo_q;
	logic [DIM_BITS-1:0]     rem_q;
	logic [DIM_BITS-1:0]     divisor_q;
	logic [DIM_BITS:0]       shifted;
	logic [DIM_BITS:0]       diff;
	logic                    fits;

	assign shifted = {rem_q, quo_q[POS_BITS-1]};
	assign diff    = shifted - {1'b0, divisor_q};
	assign fits    = shifted >= {1'b0, divisor_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + DIV_CNT_BITS'(1);
				if (cnt_q == DIV_CNT_BITS'(POS_BITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q     <= req.dividend;
			rem_q     <= '0;
			divisor_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DIM_BITS-1:0] : shifted[DIM_BITS-1:0];
			quo_q <= {quo_q[POS_BITS-2:0], fits};
		end
	end

	// The row index is below 256 and the column below the width, so both fit.
	assign res.done      = done_q;
	assign res.quotient  = quo_q[COORD_BITS-1:0];
	assign res.remainder = rem_q[COORD_BITS-1:0];

endmodule

[rtl/icra_mac.sv]
// Shared multiply-accumulate unit: one kernel tap per cycle, then magnitude,
// fraction shift and saturation of the sum. Depends on icra_pkg.
module icra_mac (
	input  logic                        clk,
	input  logic                        arst_n,
	input  icra_pkg::mac_ctl_t          ctl,
	input  logic [icra_pkg::PIXEL_BITS-1:0] pixel,
	output icra_pkg::mac_st_t           st
);
	import icra_pkg::*;

	logic                         vld_s1;
	logic                         vld_s2;
	logic signed [COEF_BITS-1:0]  coef_s1;
	logic signed [PROD_BITS-1:0]  prod_s2;
	logic signed [ACC_BITS-1:0]   acc_q;
	logic [ACC_BITS-1:0]          mag;
	logic                         over;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= ctl.tap_vld;
			vld_s2 <= vld_s1;
		end
	end

	// The coefficient travels alongside the memory read so it meets its pixel.
	always_ff @(posedge clk) begin
		coef_s1 <= ctl.coef;
		prod_s2 <= $signed({1'b0, pixel}) * coef_s1;
		if (ctl.clear) begin
			acc_q <= '0;
		end else if (vld_s2) begin
			acc_q <= acc_q + ACC_BITS'(prod_s2);
		end
	end

	assign mag  = acc_q[ACC_BITS-1] ? ACC_BITS'(-acc_q) : ACC_BITS'(acc_q);
	assign over = |mag[ACC_BITS-1:COEF_FRAC_BITS+PIXEL_BITS];

	assign st.busy    = vld_s1 | vld_s2;
	assign st.clipped = over;
	assign st.value   = over ? {PIXEL_BITS{1'b1}} : mag[COEF_FRAC_BITS +: PIXEL_BITS];

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the mirror-border convolution block.
// Depends on icra_pkg and image_convolution_reflect_abs_top; a scoreboard class
// predicts each filtered pixel and checks the output beats in order.
module tb_top;
	import icra_pkg::*;

	typedef enum int {PIX_FULL, PIX_EXTREME, PIX_DIM} pixel_style_e;
	typedef enum int {
		SHAPE_PLAIN, SHAPE_NOISY, SHAPE_RESTART, SHAPE_PAUSE, SHAPE_SHRINK_READ, SHAPE_SHRINK_LOAD
	} frame_shape_e;

	class conv_scoreboard;
		bit [PIXEL_BITS-1:0] frame_pixels [STORE_DEPTH];
		int unsigned         load_pos;
		int unsigned         read_pos;
		bit                  frame_ready;
		bit [DIM_BITS-1:0]   width_reg;
		bit [DIM_BITS-1:0]   height_reg;
		bit [KSIZE_BITS-1:0] kwidth_reg;
		bit [KSIZE_BITS-1:0] kheight_reg;
		bit [ROW_BITS-1:0]   kernel_rows [KERNEL_MAX];
		out_beat_t           filtered_due [$];
		int                  mismatches;

		function new();
			width_reg   = DIM_BITS'(DIM_MAX);
			height_reg  = DIM_BITS'(DIM_MAX);
			kwidth_reg  = KSIZE_BITS'(KERNEL_MAX);
			kheight_reg = KSIZE_BITS'(KERNEL_MAX);
			foreach (kernel_rows[i]) kernel_rows[i] = '0;
		endfunction

		function int clamp_range(input int v, input int lo, input int hi);
			if (v < lo) return lo;
			if (v > hi) return hi;
			return v;
		endfunction

		function int cols();
			return clamp_range(width_reg, DIM_MIN, DIM_MAX);
		endfunction

		function int rows();
			return clamp_range(height_reg, DIM_MIN, DIM_MAX);
		endfunction

		function int reflect(input int i, input int n);
			if (i < 0) i = -i;
			if (i >= n) i = (n - 1) + (n - i);
			if (i < 0) i = 0;
			if (i >= n) i = n - 1;
			return i;
		endfunction

		function int outstanding();
			return filtered_due.size();
		endfunction

		function void set_register(input logic [CFG_IDX_BITS-1:0] idx,
			input logic [ROW_BITS-1:0] data);
			case (idx)
				CFG_IMAGE_WIDTH:   width_reg = data[DIM_BITS-1:0];
				CFG_IMAGE_HEIGHT:  height_reg = data[DIM_BITS-1:0];
				CFG_KERNEL_WIDTH:  kwidth_reg = data[KSIZE_BITS-1:0];
				CFG_KERNEL_HEIGHT: kheight_reg = data[KSIZE_BITS-1:0];
				CFG_ROW_TOP:       kernel_rows[0] = data;
				CFG_ROW_MID:       kernel_rows[1] = data;
				CFG_ROW_BOTTOM:    kernel_rows[2] = data;
				default:           ;
			endcase
		endfunction

		// Advances the frame state for one accepted input beat and queues the
		// filtered pixel it calls for. Returns 1 unless the beat was dropped.
		function bit note_input(input in_beat_t beat);
			int unsigned w, h, size, pos;
			int kw, kh, x, y, xx, yy, i, j;
			logic signed [COEF_BITS-1:0] c;
			longint acc, mag;
			out_beat_t res;
			w = cols();
			h = rows();
			size = w * h;
			if (beat.func == FUNC_LOAD) begin
				if (frame_ready) begin
					frame_ready = 1'b0;
					load_pos = 0;
				end
				pos = (load_pos >= size) ? size - 1 : load_pos;
				frame_pixels[pos] = beat.pixel;
				if (pos + 1 >= size) begin
					frame_ready = 1'b1;
					read_pos = 0;
					load_pos = 0;
				end else begin
					load_pos = pos + 1;
				end
				return 1'b1;
			end
			if (!frame_ready) return 1'b0;

			pos = (read_pos >= size) ? size - 1 : read_pos;
			kw = clamp_range(kwidth_reg, 1, KERNEL_MAX);
			kh = clamp_range(kheight_reg, 1, KERNEL_MAX);
			x = pos % w;
			y = pos / w;
			acc = 0;
			for (i = 0; i < kh; i++) begin
				yy = reflect(y + i - kh / 2, h);
				for (j = 0; j < kw; j++) begin
					xx = reflect(x + j - kw / 2, w);
					c = kernel_rows[i][j*COEF_BITS +: COEF_BITS];
					acc += longint'(c) * longint'(frame_pixels[yy * w + xx]);
				end
			end
			mag = (acc < 0) ? -acc : acc;
			mag = mag >> COEF_FRAC_BITS;
			res.clipped = (mag > 65535);
			res.value = res.clipped ? '1 : mag[PIXEL_BITS-1:0];
			res.last = (pos + 1 >= size);
			filtered_due.push_back(res);
			if (res.last) begin
				frame_ready = 1'b0;
				load_pos = 0;
				read_pos = 0;
			end else begin
				read_pos = pos + 1;
			end
			return 1'b1;
		endfunction

		task report(input string msg);
			$display("tb_top: mismatch at %0t: %s", $realtime, msg);
			mismatches++;
		endtask

		task check_result(input out_beat_t got);
			out_beat_t want;
			if (filtered_due.size() == 0) begin
				report($sformatf("output beat with nothing due (value %0d)", got.value));
				return;
			end
			want = filtered_due.pop_front();
			if (got.value !== want.value)
				report($sformatf("value %0d, expected %0d", got.value, want.value));
			if (got.clipped !== want.clipped)
				report($sformatf("clipped %b, expected %b", got.clipped, want.clipped));
			if (got.last !== want.last)
				report($sformatf("last %b, expected %b", got.last, want.last));
		endtask
	endclass

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    cfg_we = 1'b0;
	logic [CFG_IDX_BITS-1:0] cfg_index = '0;
	logic [ROW_BITS-1:0]     cfg_data = '0;
	logic                    in_valid = 1'b0;
	logic                    in_stall;
	in_beat_t                in_data = '0;
	logic                    out_valid;
	logic                    out_stall = 1'b0;
	out_beat_t               out_data;

	conv_scoreboard sb = new();
	bit sender_quiet;
	bit recv_quiet;
	bit hold_long;
	int items_done;

	image_convolution_reflect_abs_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#8_000_000;
		$display("tb_top: FAIL");
		$finish;
	end

	// Result side: a random stall before each beat, plus one long hold on request.
	initial begin : result_sink
		int unsigned pause;
		forever begin
			if (hold_long) begin
				out_stall <= 1'b1;
				repeat (300) @(posedge clk);
				hold_long = 1'b0;
			end
			pause = recv_quiet ? 0 : $urandom_range(0, 12);
			if (pause != 0) begin
				out_stall <= 1'b1;
				repeat (pause) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (out_valid !== 1'b1);
			sb.check_result(out_data);
		end
	end

	task automatic send_beat(input logic fn, input logic [PIXEL_BITS-1:0] pixel);
		in_beat_t beat;
		int unsigned gap;
		beat.func = fn;
		beat.pixel = pixel;
		gap = sender_quiet ? 0 : $urandom_range(0, 12);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= beat;
		do @(posedge clk); while (in_stall !== 1'b0);
		if (sb.note_input(beat)) items_done++;
	endtask

	task automatic await_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.outstanding() != 0) @(posedge clk);
	endtask

	// Idle point: nothing due, and long enough for a request still in flight.
	task automatic settle();
		await_results();
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [ROW_BITS-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		sb.set_register(idx, data);
	endtask

	task automatic end_writes();
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Fills the unused upper bits of a narrow register with junk.
	function automatic logic [ROW_BITS-1:0] pad_word(input logic [ROW_BITS-1:0] v, input int bits);
		logic [ROW_BITS-1:0] junk;
		junk = ROW_BITS'({$urandom, $urandom});
		return (junk << bits) | v;
	endfunction

	task automatic program_filter(input logic [DIM_BITS-1:0] w, input logic [DIM_BITS-1:0] h,
		input logic [KSIZE_BITS-1:0] kw, input logic [KSIZE_BITS-1:0] kh,
		input logic [ROW_BITS-1:0] top, input logic [ROW_BITS-1:0] mid,
		input logic [ROW_BITS-1:0] bottom);
		write_reg(CFG_IMAGE_WIDTH, pad_word(ROW_BITS'(w), DIM_BITS));
		write_reg(CFG_IMAGE_HEIGHT, pad_word(ROW_BITS'(h), DIM_BITS));
		write_reg(CFG_KERNEL_WIDTH, pad_word(ROW_BITS'(kw), KSIZE_BITS));
		write_reg(CFG_KERNEL_HEIGHT, pad_word(ROW_BITS'(kh), KSIZE_BITS));
		write_reg(CFG_ROW_TOP, top);
		write_reg(CFG_ROW_MID, mid);
		write_reg(CFG_ROW_BOTTOM, bottom);
		end_writes();
	endtask

	// Never grows the frame, so no store entry beyond the loaded ones is read.
	task automatic shrink_frame();
		write_reg(CFG_IMAGE_WIDTH,
			pad_word(ROW_BITS'($urandom_range(DIM_MIN, sb.cols())), DIM_BITS));
		write_reg(CFG_IMAGE_HEIGHT,
			pad_word(ROW_BITS'($urandom_range(DIM_MIN, sb.rows())), DIM_BITS));
		end_writes();
	endtask

	function automatic logic [COEF_BITS-1:0] pick_coef();
		case ($urandom_range(0, 7))
			0:       return 16'h7FFF;
			1:       return 16'h8000;
			2:       return 16'h1000;
			3:       return 16'hF000;
			4:       return 16'h0000;
			5, 6:    return 16'($urandom_range(0, 8192)) - 16'd4096;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [ROW_BITS-1:0] random_row();
		return {pick_coef(), pick_coef(), pick_coef()};
	endfunction

	function automatic logic [DIM_BITS-1:0] pick_dim();
		case ($urandom_range(0, 7))
			0:       return DIM_BITS'($urandom_range(0, 3));
			1:       return DIM_BITS'(DIM_MIN);
			default: return DIM_BITS'($urandom_range(4, 9));
		endcase
	endfunction

	function automatic logic [PIXEL_BITS-1:0] pick_pixel(input pixel_style_e style);
		case (style)
			PIX_EXTREME: begin
				case ($urandom_range(0, 2))
					0:       return '1;
					1:       return '0;
					default: return 16'($urandom);
				endcase
			end
			PIX_DIM:     return 16'($urandom_range(0, 255));
			default:     return 16'($urandom);
		endcase
	endfunction

	// One frame: load until full, then read according to the shape. The first
	// load also restarts a frame that was left partly read.
	task automatic run_frame(input pixel_style_e style, input frame_shape_e shape);
		int unsigned size;
		int unsigned cut;
		size = sb.cols() * sb.rows();
		send_beat(FUNC_LOAD, pick_pixel(style));
		if (shape == SHAPE_SHRINK_LOAD) begin
			cut = $urandom_range(1, size - 2);
			repeat (cut) send_beat(FUNC_LOAD, pick_pixel(style));
			settle();
			shrink_frame();
		end
		while (!sb.frame_ready) begin
			if (shape == SHAPE_NOISY && $urandom_range(0, 3) == 0)
				send_beat(FUNC_READ, 16'($urandom));
			else
				send_beat(FUNC_LOAD, pick_pixel(style));
		end

		size = sb.cols() * sb.rows();
		cut = $urandom_range(1, size - 1);
		case (shape)
			SHAPE_RESTART: begin
				repeat (cut) send_beat(FUNC_READ, 16'($urandom));
				return;
			end
			SHAPE_PAUSE: begin
				repeat (cut) send_beat(FUNC_READ, 16'($urandom));
				await_results();
			end
			SHAPE_SHRINK_READ: begin
				repeat (cut) send_beat(FUNC_READ, 16'($urandom));
				settle();
				shrink_frame();
			end
			default: ;
		endcase
		while (sb.frame_ready) send_beat(FUNC_READ, 16'($urandom));
	endtask

	initial begin : stimulus
		int i;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A request before any frame is loaded is dropped.
		send_beat(FUNC_READ, 16'hFFFF);
		settle();
		program_filter(9'd4, 9'd4, 2'd3, 2'd3,
			{16'h1000, 16'h8000, 16'h7FFF},
			{16'hC000, 16'h0001, 16'hFFFF},
			{16'h7FFF, 16'h8000, 16'h0800});
		for (i = 0; i < 16; i++)
			send_beat(FUNC_LOAD, (i % 3 == 0) ? 16'hFFFF : (i % 3 == 1) ? 16'h0000 : 16'(i * 4099));
		repeat (6) send_beat(FUNC_READ, 16'h0000);

		// Back pressure: the sink holds off while requests keep coming.
		settle();
		sender_quiet = 1'b1;
		recv_quiet = 1'b0;
		program_filter(9'd6, 9'd6, 2'd3, 2'd3, random_row(), random_row(), random_row());
		hold_long = 1'b1;
		run_frame(PIX_FULL, SHAPE_PLAIN);

		while (items_done < 600) begin
			settle();
			sender_quiet = ($urandom_range(0, 4) == 0);
			recv_quiet = ($urandom_range(0, 4) == 0);
			program_filter(pick_dim(), pick_dim(), KSIZE_BITS'($urandom_range(0, 3)),
				KSIZE_BITS'($urandom_range(0, 3)), random_row(), random_row(), random_row());
			repeat ($urandom_range(1, 3))
				run_frame(pixel_style_e'($urandom_range(0, 2)),
					frame_shape_e'($urandom_range(0, 5)));
		end

		settle();
		if (sb.mismatches == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule

[filelist.f]
rtl/icra_pkg.sv
rtl/icra_ram.sv
rtl/icra_div.sv
rtl/icra_mac.sv
rtl/image_convolution_reflect_abs_top.sv
tb/sv/tb_top.sv
